// ----- hdl/pds_pkg.sv -----
// ---------------------------------------------------------------------------
// pds_pkg
// Shared types, codes and constants of the power domain sequencer.
// ---------------------------------------------------------------------------
package pds_pkg;

	// Default domain count; the domain field addresses at most eight
	localparam int DOMAIN_COUNT_DEF = 8;

	localparam int DOM_W   = 3;
	localparam int MASK_W  = 8;
	localparam int WAIT_W  = 9;
	localparam int POLL_W  = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_GET  = 2'd2,
		OP_TICK_ALT = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_REJECT  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DUMMY_MASK   = 2'd0,
		CFG_HW_MODE_MASK = 2'd1,
		CFG_EXEMPT       = 2'd2,
		CFG_POLL_LIMIT   = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_ON_A  = 4'd1,
		PH_ON_B  = 4'd2,
		PH_ON_C  = 4'd3,
		PH_OFF_A = 4'd4,
		PH_OFF_B = 4'd5,
		PH_HW_W  = 4'd6,
		PH_P_SW  = 4'd7,
		PH_P_HW  = 4'd8,
		PH_TOUT  = 4'd9
	} phase_t;

	// Control bits of one domain
	typedef logic [4:0] ctrl_bits_t;
	localparam ctrl_bits_t CB_SLEEP1 = 5'b00001;
	localparam ctrl_bits_t CB_SLEEP2 = 5'b00010;
	localparam ctrl_bits_t CB_ISO    = 5'b00100;
	localparam ctrl_bits_t CB_HWMODE = 5'b01000;
	localparam ctrl_bits_t CB_AUTO   = 5'b10000;

	// Sequence timings in ticks
	localparam logic [WAIT_W-1:0] WAIT_ON_SLEEP1 = 9'd20;
	localparam logic [WAIT_W-1:0] WAIT_ON_SLEEP2 = 9'd20;
	localparam logic [WAIT_W-1:0] WAIT_ON_ISO    = 9'd10;
	localparam logic [WAIT_W-1:0] WAIT_OFF_ISO   = 9'd15;
	localparam logic [WAIT_W-1:0] WAIT_OFF_SLEEP = 9'd20;
	localparam logic [WAIT_W-1:0] WAIT_HW        = 9'd290;
	localparam logic [WAIT_W-1:0] WAIT_POLL      = 9'd4;

	// Register reset values
	localparam logic [DOM_W-1:0]  EXEMPT_RST     = 3'd2;
	localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 14'd10000;

endpackage

// ----- hdl/power_domain_sequencer.sv -----
// ---------------------------------------------------------------------------
// power_domain_sequencer
// Sequences power domain switches on and off from a stream of tick, set and
// get words; one result word per input word.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+-----------------------------
//  s_*      | in        | s_tvalid / s_tready     | tdata: request, tuser: opcode
//  m_*      | out       | m_tvalid / m_tready     | tdata: control bits, status
//  cfg_*    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One word per cycle sustained while m_tready holds: a word is captured in
//  the input stage, then the sequencing logic updates the state and loads
//  the result register, which drives m_tvalid.
//  Reset clears all control bits, recorded states and the sequencer.
//  A stalled result register holds the input stage; s_tready drops only
//  when both are full. Configuration writes are always taken.
//
module power_domain_sequencer
	import pds_pkg::*;
#(
	parameter int DOMAIN_COUNT = DOMAIN_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [2:0] domain, [3] want_on, [11:4] sw_status, [19:12] hw_status
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// [1:0] opcode
	input  logic [S_TUSER_W-1:0]  s_tuser,

	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] ctrl_domain, [3] sleep1_out, [4] sleep2_out, [5] isolation_out,
	// [6] hw_mode_out, [7] auto_on_out, [8] busy_res, [9] done_res,
	// [11:10] status_code, [12] power_state
	output logic [M_TDATA_W-1:0]  m_tdata,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Only domains reachable through the 3-bit field need storage
	localparam int NSTORE = (DOMAIN_COUNT < 8) ? DOMAIN_COUNT : 8;
	localparam int IDX_W  = (NSTORE > 1) ? $clog2(NSTORE) : 1;

	// Configuration registers
	logic [MASK_W-1:0]  dummy_mask_q;
	logic [MASK_W-1:0]  hw_mode_mask_q;
	logic [DOM_W-1:0]   exempt_q;
	logic [POLL_W-1:0]  poll_limit_q;

	// Per-domain state
	ctrl_bits_t         ctrl_q [NSTORE];
	logic [NSTORE-1:0]  rec_q;

	// Sequencer state
	phase_t             phase_q;
	logic [DOM_W-1:0]   active_q;
	logic               target_q;
	logic [WAIT_W-1:0]  wait_q;
	logic [POLL_W-1:0]  poll_q;

	// Input stage
	logic               vld_s1;
	opcode_t            op_s1;
	logic [DOM_W-1:0]   dom_s1;
	logic               want_s1;
	logic [MASK_W-1:0]  sw_st_s1;
	logic [MASK_W-1:0]  hw_st_s1;

	// Result stage
	logic               vld_s2;
	logic [M_TDATA_W-1:0] res_s2;

	logic               advance;

	assign advance   = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready  = !vld_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = vld_s2;
	assign m_tdata   = res_s2;

	// -----------------------------------------------------------------------
	// Configuration
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dummy_mask_q   <= '0;
			hw_mode_mask_q <= '0;
			exempt_q       <= EXEMPT_RST;
			poll_limit_q   <= POLL_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_DUMMY_MASK:   dummy_mask_q   <= cfg_data[MASK_W-1:0];
				CFG_HW_MODE_MASK: hw_mode_mask_q <= cfg_data[MASK_W-1:0];
				CFG_EXEMPT:       exempt_q       <= cfg_data[DOM_W-1:0];
				CFG_POLL_LIMIT:   poll_limit_q   <= cfg_data[POLL_W-1:0];
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Input stage: capture a word whenever the stage is empty or draining
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= opcode_t'(s_tuser[1:0]);
			dom_s1   <= s_tdata[2:0];
			want_s1  <= s_tdata[3];
			sw_st_s1 <= s_tdata[11:4];
			hw_st_s1 <= s_tdata[19:12];
		end
	end

	// -----------------------------------------------------------------------
	// Decode of the word in the input stage
	// -----------------------------------------------------------------------
	logic               is_req;
	logic               dom_ok;
	logic [DOM_W-1:0]   sel;
	logic [IDX_W-1:0]   sel_idx;
	logic               sel_ok;
	ctrl_bits_t         ctrl_cur;
	logic               rec_cur;
	logic               seq_busy;
	logic               record_only;
	logic               set_hw;
	logic [WAIT_W-1:0]  wait_dec;
	logic               wait_end;
	logic               poll_phase;
	logic               poll_hw;
	logic               poll_bit;
	logic               poll_hit;
	logic [POLL_W-1:0]  poll_base;
	logic               get_bit;

	always_comb begin
		is_req   = (op_s1 == OP_SET) || (op_s1 == OP_GET);
		dom_ok   = 32'(dom_s1) < DOMAIN_COUNT;
		// A tick addresses the active domain, a request its own domain
		sel      = is_req ? dom_s1 : active_q;
		sel_ok   = is_req ? dom_ok : 1'b1;
		sel_idx  = sel[IDX_W-1:0];
		ctrl_cur = ctrl_q[sel_idx];
		rec_cur  = rec_q[sel_idx];
		seq_busy = phase_q != PH_IDLE;

		record_only = dummy_mask_q[dom_s1] || (dom_s1 == exempt_q);
		set_hw      = hw_mode_mask_q[dom_s1];
		get_bit     = set_hw ? hw_st_s1[dom_s1] : sw_st_s1[dom_s1];

		wait_dec = (wait_q != '0) ? wait_q - 1'b1 : '0;
		wait_end = !is_req && seq_busy && (wait_dec == '0);

		poll_phase = (phase_q == PH_ON_C) || (phase_q == PH_OFF_B) ||
			(phase_q == PH_HW_W) || (phase_q == PH_P_SW) || (phase_q == PH_P_HW);
		poll_hw    = (phase_q == PH_HW_W) || (phase_q == PH_P_HW);
		poll_bit   = poll_hw ? hw_st_s1[active_q] : sw_st_s1[active_q];
		poll_hit   = poll_bit == target_q;
		// The first poll of a sequence loads the limit
		poll_base  = (phase_q == PH_P_SW || phase_q == PH_P_HW) ? poll_q : poll_limit_q;
	end

	// -----------------------------------------------------------------------
	// Next state of the sequencer
	// -----------------------------------------------------------------------
	phase_t             phase_d;
	logic [DOM_W-1:0]   active_d;
	logic               target_d;
	logic [WAIT_W-1:0]  wait_d;
	logic [POLL_W-1:0]  poll_d;

	always_comb begin
		phase_d  = phase_q;
		active_d = active_q;
		target_d = target_q;
		wait_d   = wait_q;
		poll_d   = poll_q;
		if (is_req) begin
			if (op_s1 == OP_SET && dom_ok && !seq_busy && !record_only) begin
				active_d = dom_s1;
				target_d = want_s1;
				priority if (set_hw) begin
					wait_d  = WAIT_HW;
					phase_d = PH_HW_W;
				end else if (want_s1) begin
					wait_d  = WAIT_ON_SLEEP1;
					phase_d = PH_ON_A;
				end else begin
					wait_d  = WAIT_OFF_ISO;
					phase_d = PH_OFF_A;
				end
			end
		end else if (seq_busy) begin
			wait_d = wait_dec;
			if (wait_dec == '0) begin
				unique case (phase_q)
					PH_ON_A: begin
						wait_d  = WAIT_ON_SLEEP2;
						phase_d = PH_ON_B;
					end
					PH_ON_B: begin
						wait_d  = WAIT_ON_ISO;
						phase_d = PH_ON_C;
					end
					PH_OFF_A: begin
						wait_d  = WAIT_OFF_SLEEP;
						phase_d = PH_OFF_B;
					end
					PH_ON_C, PH_OFF_B, PH_HW_W, PH_P_SW, PH_P_HW: begin
						poll_d = poll_base;
						if (poll_hit) begin
							phase_d = PH_IDLE;
						end else begin
							wait_d = WAIT_POLL;
							if (poll_base == '0) begin
								phase_d = PH_TOUT;
							end else begin
								poll_d  = poll_base - 1'b1;
								phase_d = poll_hw ? PH_P_HW : PH_P_SW;
							end
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// -----------------------------------------------------------------------
	// Control bit update, recorded state and result fields
	// -----------------------------------------------------------------------
	ctrl_bits_t         ctrl_d;
	logic               rec_we;
	logic               rec_val;
	logic               done;
	status_t            status;
	logic               pstate;
	ctrl_bits_t         ctrl_shown;

	always_comb begin
		ctrl_d  = ctrl_cur;
		rec_we  = 1'b0;
		rec_val = want_s1;
		done    = 1'b0;
		status  = ST_OK;
		if (is_req) begin
			priority if (!dom_ok) begin
				done = 1'b1;
			end else if (op_s1 == OP_SET) begin
				priority if (seq_busy) begin
					done   = 1'b1;
					status = ST_REJECT;
				end else if (record_only) begin
					rec_we = 1'b1;
					done   = 1'b1;
				end else if (set_hw) begin
					ctrl_d = want_s1 ? (ctrl_cur | CB_HWMODE | CB_AUTO)
						: (ctrl_cur & ~(CB_HWMODE | CB_AUTO));
				end else if (want_s1) begin
					ctrl_d = ctrl_cur | CB_SLEEP1;
				end else begin
					ctrl_d = ctrl_cur & ~CB_ISO;
				end
			end else begin
				// Dummy domains keep what was recorded
				rec_we  = !dummy_mask_q[dom_s1];
				rec_val = get_bit;
				done    = 1'b1;
			end
		end else if (wait_end) begin
			unique case (phase_q)
				PH_ON_A:  ctrl_d = ctrl_cur | CB_SLEEP1 | CB_SLEEP2;
				PH_ON_B:  ctrl_d = ctrl_cur | CB_ISO;
				PH_OFF_A: ctrl_d = ctrl_cur & ~(CB_SLEEP1 | CB_SLEEP2);
				PH_ON_C, PH_OFF_B, PH_HW_W, PH_P_SW, PH_P_HW: begin
					rec_we  = poll_hit;
					rec_val = target_q;
					done    = poll_hit;
				end
				default: begin
					done   = 1'b1;
					status = ST_TIMEOUT;
				end
			endcase
		end
		pstate     = sel_ok && (rec_we ? rec_val : rec_cur);
		ctrl_shown = sel_ok ? ctrl_d : '0;
	end

	// -----------------------------------------------------------------------
	// State registers, written once per word leaving the input stage
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			active_q <= '0;
			target_q <= 1'b0;
			wait_q   <= '0;
			poll_q   <= '0;
			rec_q    <= '0;
			for (int i = 0; i < NSTORE; i++) begin
				ctrl_q[i] <= '0;
			end
		end else if (advance) begin
			phase_q  <= phase_d;
			active_q <= active_d;
			target_q <= target_d;
			wait_q   <= wait_d;
			poll_q   <= poll_d;
			if (sel_ok) begin
				ctrl_q[sel_idx] <= ctrl_d;
				if (rec_we) begin
					rec_q[sel_idx] <= rec_val;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Result register: load on advance, drop once taken
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= {3'b000, pstate, status, done, (phase_d != PH_IDLE),
				ctrl_shown, sel};
		end
	end

endmodule

// ----- hdl/pds_checker.sv -----
// ---------------------------------------------------------------------------
// pds_checker
// Port-level checks of the power domain sequencer, bound to the top level.
// ---------------------------------------------------------------------------
module pds_checker
	import pds_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 cfg_ready
);

	// Held result must not change while stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Any error status completes the request
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[11:10] != ST_OK) |-> m_tdata[9])
		else $error("error status without done");

	// A timeout ends the sequence
	a_tout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[11:10] == ST_TIMEOUT) |-> !m_tdata[8])
		else $error("busy after timeout");

	// A rejected request leaves a sequence running
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[11:10] == ST_REJECT) |-> m_tdata[8])
		else $error("reject while idle");

	// Configuration is never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");

endmodule

bind power_domain_sequencer pds_checker u_pds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for power_domain_sequencer. Streams tick, set and get
// words into the slave port, mirrors each accepted word in a behavioural
// sequencer model and checks every result word, field by field, in order.
// Directed tests cover idle queries, the software and hardware sequences,
// poll timeouts, dummy and exempt domains; random traffic then runs under
// several register settings and idling mixes, with one long output stall.
// ---------------------------------------------------------------------------
module testbench;
	import pds_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Sequence delays in ticks, kept apart from the design's own constants
	localparam logic [8:0] DELAY_SLEEP1    = 9'd20;
	localparam logic [8:0] DELAY_SLEEP2    = 9'd20;
	localparam logic [8:0] DELAY_ISO_ON    = 9'd10;
	localparam logic [8:0] DELAY_ISO_OFF   = 9'd15;
	localparam logic [8:0] DELAY_SLEEP_OFF = 9'd20;
	localparam logic [8:0] DELAY_HW        = 9'd290;
	localparam logic [8:0] DELAY_POLL      = 9'd4;

	// Control bit positions of one domain
	localparam ctrl_bits_t SW_FIRST  = 5'b00001;
	localparam ctrl_bits_t SW_SECOND = 5'b00010;
	localparam ctrl_bits_t SW_ISO    = 5'b00100;
	localparam ctrl_bits_t SW_HWMODE = 5'b01000;
	localparam ctrl_bits_t SW_AUTO   = 5'b10000;

	localparam int DOMAINS        = 8;
	localparam int SETTLE_CYCLES  = 6;    // pipeline is two stages deep
	localparam int HOLDOFF_CYCLES = 80;
	localparam int STALL_LIMIT    = 2000;
	localparam int MAX_PRINTED    = 30;

	// Result word as it sits in m_tdata[12:0], lowest field last
	typedef struct packed {
		logic       pstate;
		logic [1:0] code;
		logic       done;
		logic       busy;
		ctrl_bits_t ctrl;
		logic [2:0] dom;
	} result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [S_TUSER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	power_domain_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Sequencer model: registers, per-domain state and the running sequence
	// -----------------------------------------------------------------------
	logic [7:0]  dummy_cfg      = 8'h00;
	logic [7:0]  hwsel_cfg      = 8'h00;
	logic [2:0]  exempt_cfg     = 3'd2;
	logic [13:0] poll_limit_cfg = 14'd10000;

	ctrl_bits_t  ctrl_of [DOMAINS];
	logic        state_of [DOMAINS];
	phase_t      seq_phase   = PH_IDLE;
	logic [2:0]  seq_domain  = '0;
	logic        seq_target  = 1'b0;
	logic [8:0]  delay_left  = '0;
	logic [13:0] polls_left  = '0;

	result_t pending_results [$];

	// Slowly drifting status bits, so polls neither always pass nor always fail
	logic [7:0] plant_sw = 8'h00;
	logic [7:0] plant_hw = 8'h00;

	int gap_pct    = 0;
	int stall_pct  = 0;
	int holdoff_asked  = 0;
	int holdoff_served = 0;
	int hold_left      = 0;

	int error_count  = 0;
	int words_sent   = 0;
	int results_seen = 0;
	int n_started    = 0;
	int n_completed  = 0;
	int n_timeouts   = 0;
	int n_rejects    = 0;
	int n_gets       = 0;
	int idle_cycles  = 0;

	initial begin
		for (int i = 0; i < DOMAINS; i++) begin
			ctrl_of[i] = '0;
			state_of[i] = 1'b0;
		end
	end

	task automatic log_mismatch(input string msg);
		if (error_count < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	// One status poll of the active domain; hit ends the sequence, miss arms
	// the next 4-tick wait or the final wait before a timeout
	task automatic poll_domain(input logic hw_path, input logic [7:0] sw,
			input logic [7:0] hw, output logic finished);
		logic [7:0] live;
		live = hw_path ? hw : sw;
		finished = 1'b0;
		if (live[seq_domain] == seq_target) begin
			state_of[seq_domain] = seq_target;
			seq_phase = PH_IDLE;
			finished = 1'b1;
		end else begin
			delay_left = DELAY_POLL;
			if (polls_left == 0) begin
				seq_phase = PH_TOUT;
			end else begin
				polls_left--;
				seq_phase = hw_path ? PH_P_HW : PH_P_SW;
			end
		end
	endtask

	// Advance the model by one accepted word and queue the result it implies
	task automatic predict_word(input opcode_t op, input logic [2:0] dom, input logic on,
			input logic [7:0] sw, input logic [7:0] hw);
		result_t r;
		logic [2:0] shown;
		logic [7:0] live;
		logic finished;
		r = '0;
		finished = 1'b0;
		if (op == OP_SET || op == OP_GET) begin
			// the domain field cannot address past the eighth domain here
			shown = dom;
			r.done = 1'b1;
			if (op == OP_GET) begin
				live = hwsel_cfg[dom] ? hw : sw;
				if (!dummy_cfg[dom])
					state_of[dom] = live[dom];
				n_gets++;
			end else if (seq_phase != PH_IDLE) begin
				r.code = ST_REJECT;
				n_rejects++;
			end else if (dummy_cfg[dom] || dom == exempt_cfg) begin
				state_of[dom] = on;
			end else begin
				r.done = 1'b0;
				seq_domain = dom;
				seq_target = on;
				n_started++;
				if (hwsel_cfg[dom]) begin
					if (on)
						ctrl_of[dom] = ctrl_of[dom] | SW_HWMODE | SW_AUTO;
					else
						ctrl_of[dom] = ctrl_of[dom] & ~(SW_HWMODE | SW_AUTO);
					delay_left = DELAY_HW;
					seq_phase = PH_HW_W;
				end else if (on) begin
					ctrl_of[dom] = ctrl_of[dom] | SW_FIRST;
					delay_left = DELAY_SLEEP1;
					seq_phase = PH_ON_A;
				end else begin
					ctrl_of[dom] = ctrl_of[dom] & ~SW_ISO;
					delay_left = DELAY_ISO_OFF;
					seq_phase = PH_OFF_A;
				end
			end
		end else begin
			// both tick codes behave alike
			if (seq_phase != PH_IDLE) begin
				if (delay_left != 0)
					delay_left--;
				if (delay_left == 0) begin
					unique case (seq_phase)
						PH_ON_A: begin
							ctrl_of[seq_domain] = ctrl_of[seq_domain] |
								SW_FIRST | SW_SECOND;
							delay_left = DELAY_SLEEP2;
							seq_phase = PH_ON_B;
						end
						PH_ON_B: begin
							ctrl_of[seq_domain] = ctrl_of[seq_domain] | SW_ISO;
							delay_left = DELAY_ISO_ON;
							seq_phase = PH_ON_C;
						end
						PH_OFF_A: begin
							ctrl_of[seq_domain] = ctrl_of[seq_domain] &
								~(SW_FIRST | SW_SECOND);
							delay_left = DELAY_SLEEP_OFF;
							seq_phase = PH_OFF_B;
						end
						PH_ON_C, PH_OFF_B: begin
							polls_left = poll_limit_cfg;
							poll_domain(1'b0, sw, hw, finished);
						end
						PH_HW_W: begin
							polls_left = poll_limit_cfg;
							poll_domain(1'b1, sw, hw, finished);
						end
						PH_P_SW: poll_domain(1'b0, sw, hw, finished);
						PH_P_HW: poll_domain(1'b1, sw, hw, finished);
						default: begin
							seq_phase = PH_IDLE;
							r.done = 1'b1;
							r.code = ST_TIMEOUT;
							n_timeouts++;
						end
					endcase
				end
			end
			if (finished) begin
				r.done = 1'b1;
				n_completed++;
			end
			shown = seq_domain;
		end
		r.dom = shown;
		r.ctrl = ctrl_of[shown];
		r.pstate = state_of[shown];
		r.busy = (seq_phase != PH_IDLE);
		pending_results.push_back(r);
	endtask

	// -----------------------------------------------------------------------
	// Drivers
	// -----------------------------------------------------------------------

	// Offer one word after a random gap, hold it until taken, then predict
	task automatic send_word(input opcode_t op, input logic [2:0] dom, input logic on,
			input logic [7:0] sw, input logic [7:0] hw);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, hw, sw, on, dom};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
		predict_word(op, dom, on, sw, hw);
	endtask

	task automatic tick_run(input int count, input logic [7:0] sw, input logic [7:0] hw);
		for (int i = 0; i < count; i++)
			send_word(OP_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)), sw, hw);
	endtask

	// Drop valid, let every expected word come back, then allow the pipeline to empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers while the block is quiet
	task automatic configure(input logic [7:0] dummy, input logic [7:0] hwsel,
			input logic [2:0] exempt, input logic [13:0] plimit);
		logic [13:0] vals [4];
		settle();
		// spare upper bits carry junk that the register must ignore
		vals[0] = {6'($urandom), dummy};
		vals[1] = {6'($urandom), hwsel};
		vals[2] = {11'($urandom), exempt};
		vals[3] = plimit;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			unique case (cfg_index_t'(i))
				CFG_DUMMY_MASK:   dummy_cfg = vals[i][7:0];
				CFG_HW_MODE_MASK: hwsel_cfg = vals[i][7:0];
				CFG_EXEMPT:       exempt_cfg = vals[i][2:0];
				default:          poll_limit_cfg = vals[i];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Random word: sets, gets and ticks while idle, mostly ticks while a
	// sequence runs, with stray sets, gets and noisy status mixed in
	task automatic send_random_word();
		opcode_t op;
		logic [7:0] sw;
		logic [7:0] hw;
		int pick;
		if ($urandom_range(99) < 10)
			plant_sw = plant_sw ^ (8'h01 << $urandom_range(7));
		if ($urandom_range(99) < 10)
			plant_hw = plant_hw ^ (8'h01 << $urandom_range(7));
		if ($urandom_range(99) < 3) begin
			plant_sw = 8'($urandom);
			plant_hw = 8'($urandom);
		end
		sw = plant_sw;
		hw = plant_hw;
		if ($urandom_range(99) < 15) begin
			sw = 8'($urandom);
			hw = 8'($urandom);
		end
		pick = $urandom_range(99);
		if (seq_phase == PH_IDLE) begin
			if (pick < 35)
				op = OP_SET;
			else if (pick < 50)
				op = OP_GET;
			else
				op = OP_TICK;
		end else begin
			if (pick < 4)
				op = OP_SET;
			else if (pick < 14)
				op = OP_GET;
			else
				op = OP_TICK;
		end
		if (op == OP_TICK && $urandom_range(9) == 0)
			op = OP_TICK_ALT;
		send_word(op, 3'($urandom_range(7)), 1'($urandom_range(1)), sw, hw);
	endtask

	// -----------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (holdoff_served != holdoff_asked) begin
			holdoff_served <= holdoff_asked;
			hold_left <= HOLDOFF_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare each taken result word with the oldest expectation
	always @(posedge clk) begin : check_result
		result_t got;
		result_t want;
		string bad;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[12:0]);
			if (pending_results.size() == 0) begin
				log_mismatch($sformatf("unexpected result word %h", m_tdata));
			end else begin
				want = pending_results.pop_front();
				bad = "";
				if (got.dom !== want.dom)         bad = {bad, " ctrl_domain"};
				if (got.ctrl[0] !== want.ctrl[0]) bad = {bad, " sleep1"};
				if (got.ctrl[1] !== want.ctrl[1]) bad = {bad, " sleep2"};
				if (got.ctrl[2] !== want.ctrl[2]) bad = {bad, " isolation"};
				if (got.ctrl[3] !== want.ctrl[3]) bad = {bad, " hw_mode"};
				if (got.ctrl[4] !== want.ctrl[4]) bad = {bad, " auto_on"};
				if (got.busy !== want.busy)       bad = {bad, " busy"};
				if (got.done !== want.done)       bad = {bad, " done"};
				if (got.code !== want.code)       bad = {bad, " status"};
				if (got.pstate !== want.pstate)   bad = {bad, " power_state"};
				if (m_tdata[15:13] !== 3'b000)    bad = {bad, " padding"};
				if (bad != "")
					log_mismatch($sformatf("result %0d:%s got %h expected %h",
						results_seen, bad, m_tdata, {3'b000, want}));
			end
			results_seen++;
		end
	end

	// Watchdog: end the run if no handshake of any kind happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("power_domain_sequencer verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Ticks and queries with nothing running, exempt domain at its reset index
	task automatic test_idle_requests();
		send_word(OP_TICK, 3'd5, 1'b1, 8'hFF, 8'hFF);
		send_word(OP_TICK_ALT, 3'd0, 1'b0, 8'h00, 8'h00);
		send_word(OP_GET, 3'd0, 1'b0, 8'h01, 8'h00);
		send_word(OP_GET, 3'd7, 1'b1, 8'h00, 8'h80);
		send_word(OP_GET, 3'd7, 1'b0, 8'h80, 8'h00);
		send_word(OP_SET, 3'd2, 1'b1, 8'h00, 8'h00);
		send_word(OP_SET, 3'd2, 1'b0, 8'hFF, 8'hFF);
	endtask

	// Software on and off, a busy reject, a get during the sequence and a missed poll
	task automatic test_sw_sequences();
		send_word(OP_SET, 3'd0, 1'b1, 8'h00, 8'h00);
		send_word(OP_SET, 3'd1, 1'b1, 8'h00, 8'h00);
		send_word(OP_GET, 3'd0, 1'b1, 8'h00, 8'hFF);
		tick_run(48, 8'h00, 8'hFF);
		tick_run(4, 8'h01, 8'h00);
		tick_run(3, 8'h01, 8'h00);
		send_word(OP_SET, 3'd0, 1'b0, 8'h01, 8'h00);
		tick_run(35, 8'h01, 8'h00);
		tick_run(4, 8'h00, 8'hFF);
	endtask

	// Hardware mode on every domain, longest poll budget, exempt domain zero
	task automatic test_hw_sequences();
		configure(8'h00, 8'hFF, 3'd0, 14'd16383);
		send_word(OP_SET, 3'd7, 1'b1, 8'hFF, 8'h00);
		tick_run(290, 8'hFF, 8'h00);
		tick_run(8, 8'h00, 8'h00);
		tick_run(4, 8'h00, 8'h80);
		send_word(OP_GET, 3'd7, 1'b0, 8'h00, 8'h80);
		send_word(OP_SET, 3'd0, 1'b1, 8'h00, 8'h00);
		send_word(OP_SET, 3'd7, 1'b0, 8'h80, 8'h80);
		tick_run(290, 8'hFF, 8'h00);
	endtask

	// No poll retries: one miss leads to a timeout, in both modes
	task automatic test_timeouts();
		configure(8'h00, 8'h00, 3'd7, 14'd0);
		send_word(OP_SET, 3'd3, 1'b1, 8'hFF, 8'hFF);
		tick_run(54, 8'h00, 8'hFF);
		send_word(OP_SET, 3'd7, 1'b1, 8'h00, 8'h00);
		configure(8'h00, 8'h08, 3'd7, 14'd0);
		send_word(OP_SET, 3'd3, 1'b0, 8'h00, 8'h00);
		tick_run(294, 8'h00, 8'hFF);
	endtask

	// Every domain a dummy: sets only record, gets do not refresh
	task automatic test_dummy_domains();
		configure(8'hFF, 8'h00, 3'd2, 14'd10000);
		send_word(OP_SET, 3'd4, 1'b1, 8'h00, 8'h00);
		send_word(OP_GET, 3'd4, 1'b0, 8'h00, 8'h00);
		send_word(OP_SET, 3'd6, 1'b0, 8'hFF, 8'hFF);
		send_word(OP_GET, 3'd6, 1'b1, 8'hFF, 8'hFF);
	endtask

	// Hold the output off for a long stretch while words keep coming, so
	// that both stages fill and s_tready drops
	task automatic test_output_stall();
		configure(8'h00, 8'h00, 3'd1, 14'd2);
		gap_pct = 0;
		stall_pct = 0;
		holdoff_asked++;
		for (int i = 0; i < 24; i++)
			send_random_word();
	endtask

	task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
			input int count);
		gap_pct = sender_idle;
		stall_pct = receiver_stall;
		for (int i = 0; i < count; i++)
			send_random_word();
		gap_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_requests();
		test_sw_sequences();
		test_hw_sequences();
		test_timeouts();
		test_dummy_domains();
		test_output_stall();

		// random traffic, one register setting per idling mix
		configure(8'h00, 8'h00, 3'd0, 14'd3);
		test_random_traffic(0, 0, 80);
		configure(8'h11, 8'hF0, 3'd7, 14'd0);
		test_random_traffic(58, 0, 80);
		configure(8'h80, 8'h0F, 3'd5, 14'd16383);
		test_random_traffic(0, 58, 80);
		configure(8'h24, 8'h5A, 3'd2, 14'd1);
		test_random_traffic(38, 38, 80);

		settle();
		$display("Run covered %0d words and %0d result words: %0d sequences started,",
			words_sent, results_seen, n_started);
		$display("%0d completed, %0d timed out, %0d sets rejected while busy, %0d gets.",
			n_completed, n_timeouts, n_rejects, n_gets);
		if (error_count == 0)
			$display("power_domain_sequencer verification clean");
		else
			$display("power_domain_sequencer verification failed");
		$finish;
	end

endmodule
